/* rtl/pdsc_pkg.sv */
// Dual pedal sensor check: shared types, widths, codes and reset values.
// No dependencies; imported by pdsc_lane, pdsc_merge and the top level.
package pdsc_pkg;

	localparam int ADC_BITS  = 12;
	localparam int FRAC_BITS = 8;

	localparam int RAW_W  = ADC_BITS;
	localparam int DZ_W   = 8;
	localparam int TOL_W  = 8;
	localparam int DEV_W  = 15;
	localparam int PCT_W  = 15;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = (RAW_W > DEV_W) ? RAW_W : DEV_W;

	// full scale percent and the width an internal percent needs
	localparam int FULL      = 100 << FRAC_BITS;
	localparam int PCT_INT_W = $clog2(FULL + 1);
	localparam int NUM_W     = RAW_W + PCT_INT_W;
	localparam int CMP_W     = (PCT_INT_W > DEV_W) ? PCT_INT_W : DEV_W;

	// lane tag carried alongside the divider: fault flag and result select
	localparam int SEL_W = 2;
	localparam int TAG_W = SEL_W + 1;

	// accept -> s1 -> product -> divider stages -> merged result
	localparam int LAT = PCT_INT_W + 3;

	localparam logic [SEL_W-1:0] SEL_DIV  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_ZERO = 2'd1;
	localparam logic [SEL_W-1:0] SEL_FULL = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_IMPL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FAULT = 2'd2;

	localparam logic [IDX_W-1:0] REG_S1_MIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_S1_MAX  = 3'd1;
	localparam logic [IDX_W-1:0] REG_S2_MIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_S2_MAX  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DZ      = 3'd4;
	localparam logic [IDX_W-1:0] REG_TOL     = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEV_LIM = 3'd6;

	localparam logic [RAW_W-1:0] RAW_MIN_RST = '0;
	localparam logic [RAW_W-1:0] RAW_MAX_RST = RAW_W'(4095);
	localparam logic [DZ_W-1:0]  DZ_RST      = '0;
	localparam logic [TOL_W-1:0] TOL_RST     = '0;
	localparam logic [DEV_W-1:0] DEV_RST     = DEV_W'(2560);

	typedef struct packed {
		logic [RAW_W-1:0] sensor1_raw;
		logic [RAW_W-1:0] sensor2_raw;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PCT_W-1:0]  pedal_percent;
		logic [PCT_W-1:0]  sensor1_percent;
		logic [PCT_W-1:0]  sensor2_percent;
	} out_t;

	typedef struct packed {
		logic                 fault;
		logic [PCT_INT_W-1:0] pct;
	} lane_res_t;

endpackage

/* rtl/pdsc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a tag pipe.
// Generic; widths come from the instantiating lane.
module pdsc_div #(
	parameter int NW = 27,
	parameter int DW = 12,
	parameter int QW = 15,
	parameter int TW = 3
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);

	logic [NW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [TW-1:0] tag_s [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic [NW-1:0] rem_in;
			logic [NW-1:0] dsh;
			logic [QW-1:0] quo_in;
			logic [DW-1:0] den_in;
			logic [TW-1:0] tag_k;

			if (k == 0) begin : g_first
				assign rem_in = num;
				assign quo_in = '0;
				assign den_in = den;
				assign tag_k  = tag_in;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign quo_in = quo_s[k-1];
				assign den_in = den_s[k-1];
				assign tag_k  = tag_s[k-1];
			end

			// quotient fits QW bits, so num < den << QW and no shift overflows
			assign dsh = NW'(den_in) << (QW - 1 - k);

			always_ff @(posedge clk) begin
				if (rem_in >= dsh) begin
					rem_s[k] <= rem_in - dsh;
					quo_s[k] <= quo_in | (QW'(1) << (QW - 1 - k));
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
				den_s[k] <= den_in;
				tag_s[k] <= tag_k;
			end
		end
	endgenerate

	assign quo     = quo_s[QW-1];
	assign tag_out = tag_s[QW-1];

endmodule

/* rtl/pdsc_lane.sv */
// One sensor lane: window check, deadzone snap, scaling product and divider.
// Depends on pdsc_pkg and pdsc_div.
module pdsc_lane (
	input  logic                       clk,
	input  logic [pdsc_pkg::RAW_W-1:0] raw,
	input  logic [pdsc_pkg::RAW_W-1:0] raw_min,
	input  logic [pdsc_pkg::RAW_W-1:0] raw_max,
	input  logic [pdsc_pkg::DZ_W-1:0]  dz,
	input  logic [pdsc_pkg::TOL_W-1:0] tol,
	output pdsc_pkg::lane_res_t        res
);
	import pdsc_pkg::*;

	localparam int EW = RAW_W + 1;

	logic [EW-1:0]        raw_e, min_e, max_e, dz_e, tol_e;
	logic                 snap_zero, snap_full, fault;
	logic [SEL_W-1:0]     sel;
	logic [RAW_W-1:0]     span, travel;
	logic [NUM_W-1:0]     num_s2;
	logic [RAW_W-1:0]     den_s2;
	logic [TAG_W-1:0]     tag_s2, tag_dv;
	logic [PCT_INT_W-1:0] quo;

	assign raw_e = EW'(raw);
	assign min_e = EW'(raw_min);
	assign max_e = EW'(raw_max);
	assign dz_e  = EW'(dz);
	assign tol_e = EW'(tol);

	// released end wins when both snap tests hold
	assign snap_zero = (raw_e + dz_e) >= max_e;
	assign snap_full = raw_e <= (min_e + dz_e);
	assign fault     = (raw_e > (max_e + tol_e)) || ((raw_e + tol_e) < min_e);

	always_comb begin
		if (snap_zero)
			sel = SEL_ZERO;
		else if (snap_full)
			sel = SEL_FULL;
		else
			sel = SEL_DIV;
	end

	// only meaningful when interpolating: then max > raw > min
	assign travel = raw_max - raw;
	assign span   = raw_max - raw_min;

	always_ff @(posedge clk) begin
		num_s2 <= NUM_W'(travel) * NUM_W'(FULL);
		den_s2 <= span;
		tag_s2 <= {fault, sel};
	end

	pdsc_div #(
		.NW(NUM_W),
		.DW(RAW_W),
		.QW(PCT_INT_W),
		.TW(TAG_W)
	) u_div (
		.clk    (clk),
		.num    (num_s2),
		.den    (den_s2),
		.tag_in (tag_s2),
		.quo    (quo),
		.tag_out(tag_dv)
	);

	// quotient stays below full scale, so no clamp is needed
	always_comb begin
		res.fault = tag_dv[TAG_W-1];
		case (tag_dv[SEL_W-1:0])
			SEL_ZERO: res.pct = '0;
			SEL_FULL: res.pct = PCT_INT_W'(FULL);
			SEL_DIV:  res.pct = quo;
			default:  res.pct = '0;
		endcase
	end

endmodule

/* rtl/pdsc_merge.sv */
// Merge stage: combines both lanes into status and averaged pedal percent.
// Depends on pdsc_pkg.
module pdsc_merge (
	input  logic                       clk,
	input  pdsc_pkg::lane_res_t        lane1,
	input  pdsc_pkg::lane_res_t        lane2,
	input  logic [pdsc_pkg::DEV_W-1:0] dev_limit,
	output pdsc_pkg::out_t             result
);
	import pdsc_pkg::*;

	logic [PCT_INT_W-1:0] diff;
	logic [PCT_INT_W:0]   sum;
	out_t                 res_q;

	assign diff = (lane1.pct > lane2.pct) ? (lane1.pct - lane2.pct) : (lane2.pct - lane1.pct);
	assign sum  = (PCT_INT_W + 1)'(lane1.pct) + (PCT_INT_W + 1)'(lane2.pct);

	always_ff @(posedge clk) begin
		res_q.sensor1_percent <= PCT_W'(lane1.pct);
		res_q.sensor2_percent <= PCT_W'(lane2.pct);
		if (lane1.fault || lane2.fault) begin
			res_q.status        <= ST_FAULT;
			res_q.pedal_percent <= '0;
		end else if (CMP_W'(diff) > CMP_W'(dev_limit)) begin
			res_q.status        <= ST_IMPL;
			res_q.pedal_percent <= '0;
		end else begin
			res_q.status        <= ST_OK;
			res_q.pedal_percent <= PCT_W'(sum[PCT_INT_W:1]);
		end
	end

	assign result = res_q;

endmodule

/* rtl/dual_pedal_sensor_check_top.sv */
// Dual pedal sensor check, top level: config registers, two lanes, merge.
// Path from the accepting edge to the result: input register, product register,
// the 15-stage bit-per-stage divider in each lane and the merge register; done
// is high in the same cycle as the result. Throughput: one item per cycle; busy
// is high only until the first edge after reset. Reset: arst_n clears the valid
// pipe and loads calibration defaults; results carry no back-pressure, each is
// shown for one cycle with done high.
// Depends on pdsc_pkg, pdsc_lane, pdsc_div, pdsc_merge.
module dual_pedal_sensor_check_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pdsc_pkg::in_t              item,
	output logic                       done,
	output pdsc_pkg::out_t             result,
	input  logic                       wr_en,
	input  logic [pdsc_pkg::IDX_W-1:0] wr_index,
	input  logic [pdsc_pkg::CFG_W-1:0] wr_data
);
	import pdsc_pkg::*;

	// calibration registers; the user must write them only while no item is in flight, which the block does not enforce
	logic [RAW_W-1:0] s1_min_q, s1_max_q, s2_min_q, s2_max_q;
	logic [DZ_W-1:0]  dz_q;
	logic [TOL_W-1:0] tol_q;
	logic [DEV_W-1:0] dev_lim_q;

	logic             rdy_q;
	logic             accept;
	logic [LAT-1:0]   vld_s;
	in_t              item_s1;
	lane_res_t        lane1, lane2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_min_q  <= RAW_MIN_RST;
			s1_max_q  <= RAW_MAX_RST;
			s2_min_q  <= RAW_MIN_RST;
			s2_max_q  <= RAW_MAX_RST;
			dz_q      <= DZ_RST;
			tol_q     <= TOL_RST;
			dev_lim_q <= DEV_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_S1_MIN:  s1_min_q  <= wr_data[RAW_W-1:0];
				REG_S1_MAX:  s1_max_q  <= wr_data[RAW_W-1:0];
				REG_S2_MIN:  s2_min_q  <= wr_data[RAW_W-1:0];
				REG_S2_MAX:  s2_max_q  <= wr_data[RAW_W-1:0];
				REG_DZ:      dz_q      <= wr_data[DZ_W-1:0];
				REG_TOL:     tol_q     <= wr_data[TOL_W-1:0];
				REG_DEV_LIM: dev_lim_q <= wr_data[DEV_W-1:0];
				default: ;
			endcase
		end
	end

	// held off only for the first cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rdy_q <= 1'b0;
		else
			rdy_q <= 1'b1;
	end

	assign busy   = !rdy_q;
	assign accept = start && !busy;

	// valid pipe tracks each item alongside the data path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[LAT-2:0], accept};
	end

	// input register; payload needs no reset, validity lives in vld_s
	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	pdsc_lane u_lane1 (
		.clk    (clk),
		.raw    (item_s1.sensor1_raw),
		.raw_min(s1_min_q),
		.raw_max(s1_max_q),
		.dz     (dz_q),
		.tol    (tol_q),
		.res    (lane1)
	);

	pdsc_lane u_lane2 (
		.clk    (clk),
		.raw    (item_s1.sensor2_raw),
		.raw_min(s2_min_q),
		.raw_max(s2_max_q),
		.dz     (dz_q),
		.tol    (tol_q),
		.res    (lane2)
	);

	pdsc_merge u_merge (
		.clk      (clk),
		.lane1    (lane1),
		.lane2    (lane2),
		.dev_limit(dev_lim_q),
		.result   (result)
	);

	assign done = vld_s[LAT-1];

	// every accepted item later yields its result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT) done)
		else $error("item accepted without a result at the expected latency");

	// pedal percent only reported when both sensors agree
	a_pedal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.pedal_percent == '0))
		else $error("pedal percent non-zero on a failed check");

	// average lies no higher than the larger sensor percent
	a_pedal_avg: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_OK) |->
			(result.pedal_percent <= result.sensor1_percent) ||
			(result.pedal_percent <= result.sensor2_percent))
		else $error("pedal percent above both sensor percents");

	// lane percents never exceed full scale
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.sensor1_percent <= PCT_W'(FULL)) &&
			(result.sensor2_percent <= PCT_W'(FULL)))
		else $error("sensor percent above full scale");

endmodule
